[hw/rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked while out of reset.
`define SMPB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication checked at every edge, reset included.
`define SMPB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/smpb_pkg.sv]
// Types, codes, constant tables and helpers of the port to MIDI bridge.
`timescale 1ns / 1ps
`default_nettype none
package smpb_pkg;

  localparam int QUEUE_DEPTH   = 4;
  localparam int PITCH_ENTRIES = 113;
  localparam int BURST_LEN     = 51;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_RESET = 2'd3;

  localparam logic [7:0] PORT_A    = 8'h98;
  localparam logic [7:0] PORT_B    = 8'h99;
  localparam logic [7:0] PORT_C    = 8'h9A;
  localparam logic [7:0] PORT_CTRL = 8'h9B;

  localparam logic [7:0] MIDI_NOTE_ON  = 8'h90;
  localparam logic [7:0] MIDI_NOTE_OFF = 8'h80;
  localparam logic [7:0] MIDI_DRUM_ON  = 8'h99;
  localparam logic [7:0] MIDI_VEL      = 8'h7F;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] address;
    logic [7:0] data;
  } smpb_in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } smpb_out_t;

  typedef enum logic [1:0] {
    JOB_READ,
    JOB_NOTE,
    JOB_DRUM,
    JOB_BURST
  } job_kind_t;

  // b0: read data, status byte or drum mask; b1: key of a note
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] b0;
    logic [7:0] b1;
  } smpb_job_t;

  localparam logic [15:0] PITCH_TAB [PITCH_ENTRIES] = '{
    16'h9741, 16'h8EBE, 16'h86BB, 16'h7F2E, 16'h780B, 16'h714E, 16'h6AED, 16'h64EC,
    16'h5F41, 16'h59E8, 16'h54D9, 16'h5015, 16'h4B95, 16'h4754, 16'h4353, 16'h3F8D,
    16'h3BFC, 16'h389E, 16'h356E, 16'h326E, 16'h2F99, 16'h2CED, 16'h2A66, 16'h2805,
    16'h25C5, 16'h23A5, 16'h21A5, 16'h1FC3, 16'h1DFB, 16'h1C4C, 16'h1AB4, 16'h1934,
    16'h17CA, 16'h1674, 16'h1531, 16'h1401, 16'h12E1, 16'h11D1, 16'h10D1, 16'h0FE1,
    16'h0EFD, 16'h0E26, 16'h0D59, 16'h0C99, 16'h0BE4, 16'h0B39, 16'h0A98, 16'h0A00,
    16'h0970, 16'h08E8, 16'h0868, 16'h07F0, 16'h077E, 16'h0712, 16'h06AC, 16'h064C,
    16'h05F2, 16'h059C, 16'h054C, 16'h0500, 16'h04B8, 16'h0474, 16'h0434, 16'h03F8,
    16'h03BF, 16'h0389, 16'h0356, 16'h0326, 16'h02F9, 16'h02CE, 16'h02A6, 16'h0280,
    16'h025C, 16'h023A, 16'h021A, 16'h01FC, 16'h01DF, 16'h01C4, 16'h01AB, 16'h0193,
    16'h017C, 16'h0167, 16'h0153, 16'h0140, 16'h012E, 16'h011D, 16'h010D, 16'h00FE,
    16'h00F0, 16'h00E2, 16'h00D5, 16'h00C9, 16'h00BE, 16'h00B3, 16'h00A9, 16'h00A0,
    16'h0097, 16'h008E, 16'h0086, 16'h007F, 16'h0078, 16'h0071, 16'h006A, 16'h0064,
    16'h005F, 16'h0059, 16'h0054, 16'h0050, 16'h004B, 16'h0047, 16'h0043, 16'h003F,
    16'h003C
  };

  localparam logic [7:0] DRUM_KEYS [8] = '{
    8'd42, 8'd46, 8'd49, 8'd48, 8'd41, 8'd38, 8'd35, 8'd0
  };

  localparam logic [7:0] BURST_HEAD [8] = '{
    8'hF0, 8'h7E, 8'h7F, 8'h09, 8'h01, 8'hF7, 8'h00, 8'h00
  };

  function automatic logic [15:0] pitch_tab(input logic [6:0] idx);
    logic [15:0] v;
    v = '0;
    if (int'(idx) < PITCH_ENTRIES) begin
      v = PITCH_TAB[idx];
    end
    return v;
  endfunction

  function automatic logic [7:0] drum_key(input logic [2:0] idx);
    return DRUM_KEYS[idx];
  endfunction

  // Byte of the reset burst: sysex head, all-sound-off per channel, programs
  function automatic logic [7:0] burst_byte(input logic [5:0] idx);
    logic [5:0]  j;
    logic [11:0] prod;
    logic [3:0]  grp;
    logic [5:0]  rem;
    logic [7:0]  v;
    j    = '0;
    prod = '0;
    grp  = '0;
    rem  = '0;
    if (idx < 6'd6) begin
      v = BURST_HEAD[idx[2:0]];
    end else if (idx < 6'd39) begin
      j    = idx - 6'd6;
      // divide by three through a reciprocal, exact below 48
      prod = 12'(j) * 12'd43;
      grp  = prod[10:7];
      rem  = j - 6'(6'(grp) * 6'd3);
      case (rem[1:0])
        2'd0:    v = 8'hB0 + 8'(grp);
        2'd1:    v = 8'h78;
        default: v = 8'h00;
      endcase
    end else begin
      j = idx - 6'd39;
      if (j[0]) begin
        v = 8'h07;
      end else begin
        v = 8'hC0 + 8'(j[5:1]);
      end
    end
    return v;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/smpb_stream_if.sv]
// Valid/ready channel carrying one item of a given payload type.
`timescale 1ns / 1ps
`default_nettype none
interface smpb_stream_if #(
  parameter type T = logic [7:0]
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hw/rtl/smpb_front.sv]
// Front end: decodes port accesses, keeps the port and note state, queues jobs.
`timescale 1ns / 1ps
`default_nettype none
module smpb_front
  import smpb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  smpb_in_t  in_item,
  output logic      job_valid,
  input  logic      job_ready,
  output smpb_job_t job
);

  typedef enum logic [1:0] {F_IDLE, F_SEARCH, F_PICK} f_state_t;

  f_state_t    state_r, state_nxt;
  logic [7:0]  latch_a_r, latch_a_nxt;
  logic [7:0]  latch_b_r, latch_b_nxt;
  logic [7:0]  latch_c_r, latch_c_nxt;
  logic [5:0]  phase_r, phase_nxt;
  logic [15:0] tcount_r [6];
  logic [15:0] tcount_nxt [6];
  logic [7:0]  skey_r [8];
  logic [7:0]  skey_nxt [8];
  logic [7:0]  sounding_r, sounding_nxt;
  logic [7:0]  setup_prev_r, setup_prev_nxt;
  logic [7:0]  pending_r, pending_nxt;
  logic [7:0]  rhythm_prev_r, rhythm_prev_nxt;
  logic        reset_sent_r, reset_sent_nxt;
  logic [6:0]  pitch_cv_r, pitch_cv_nxt;
  logic        gate_r, gate_nxt;
  logic [2:0]  srch_ch_r, srch_ch_nxt;
  logic [15:0] srch_cnt_r, srch_cnt_nxt;
  logic [6:0]  lo_r, lo_nxt;
  logic [6:0]  hi_r, hi_nxt;

  logic        accept;
  logic [2:0]  cp;
  logic [15:0] cnt_new;
  logic [7:0]  cv;
  logic        do_pc;
  logic [2:0]  ch;
  logic [6:0]  drum_mask;
  logic [6:0]  mid;
  logic [15:0] tab_i, tab_p, up, dn;
  logic [6:0]  pc, pc_cl;
  logic [7:0]  key;

  assign in_ready = (state_r == F_IDLE) && job_ready;
  assign accept   = in_valid && in_ready;

  // Pick the nearest pitch once the search has settled
  always_comb begin
    tab_i = pitch_tab(lo_r);
    tab_p = pitch_tab(lo_r - 7'd1);
    up    = tab_p - srch_cnt_r;
    dn    = srch_cnt_r - tab_i;
    if (int'(lo_r) >= PITCH_ENTRIES) begin
      pc = pitch_cv_r;
    end else if (lo_r == 7'd0) begin
      pc = '0;
    end else if (up < dn) begin
      pc = lo_r - 7'd1;
    end else begin
      pc = lo_r;
    end
    pc_cl = (pc > 7'd103) ? pc - 7'd12 : pc;
    key   = 8'(pc_cl) + 8'd24;
    mid   = 7'((8'(lo_r) + 8'(hi_r)) >> 1);
  end

  always_comb begin
    state_nxt       = state_r;
    latch_a_nxt     = latch_a_r;
    latch_b_nxt     = latch_b_r;
    latch_c_nxt     = latch_c_r;
    phase_nxt       = phase_r;
    tcount_nxt      = tcount_r;
    skey_nxt        = skey_r;
    sounding_nxt    = sounding_r;
    setup_prev_nxt  = setup_prev_r;
    pending_nxt     = pending_r;
    rhythm_prev_nxt = rhythm_prev_r;
    reset_sent_nxt  = reset_sent_r;
    pitch_cv_nxt    = pitch_cv_r;
    gate_nxt        = gate_r;
    srch_ch_nxt     = srch_ch_r;
    srch_cnt_nxt    = srch_cnt_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    job_valid       = 1'b0;
    job             = '{kind: JOB_READ, b0: 8'h00, b1: 8'h00};
    cp              = '0;
    cnt_new         = '0;
    cv              = in_item.data;
    do_pc           = 1'b0;
    ch              = '0;
    drum_mask       = rhythm_prev_r[7:1] & ~in_item.data[7:1];

    case (state_r)
      F_IDLE: begin
        if (accept) begin
          case (in_item.cmd)
            CMD_WRITE: begin
              case (in_item.address) inside
                8'h90, 8'h91, 8'h92, 8'h94, 8'h95, 8'h96: begin
                  // load one byte of a counter
                  cp = in_item.address[2] ? 3'(in_item.address[1:0]) + 3'd3
                                          : 3'(in_item.address[1:0]);
                  cnt_new = phase_r[cp] ? {in_item.data, tcount_r[cp][7:0]}
                                        : {tcount_r[cp][15:8], in_item.data};
                  tcount_nxt[cp] = cnt_new;
                  phase_nxt[cp]  = ~phase_r[cp];
                  reset_sent_nxt = 1'b0;
                  if (phase_r[cp] && pending_r[cp]) begin
                    pending_nxt[cp] = 1'b0;
                    srch_ch_nxt     = cp;
                    srch_cnt_nxt    = cnt_new;
                    lo_nxt          = '0;
                    hi_nxt          = 7'(PITCH_ENTRIES);
                    state_nxt       = F_SEARCH;
                  end
                end
                PORT_A: begin
                  gate_nxt = ~in_item.data[7];
                  if (!in_item.data[7]) begin
                    pitch_cv_nxt = {1'b0, in_item.data[5:0]};
                  end
                  reset_sent_nxt = 1'b0;
                  latch_a_nxt    = in_item.data;
                end
                PORT_B: begin
                  // falling rhythm bits play drums
                  if (drum_mask != '0) begin
                    job_valid = 1'b1;
                    job = '{kind: JOB_DRUM, b0: {1'b0, drum_mask}, b1: 8'h00};
                  end
                  rhythm_prev_nxt = in_item.data;
                  reset_sent_nxt  = 1'b0;
                  latch_b_nxt     = in_item.data;
                end
                PORT_C: begin
                  do_pc = 1'b1;
                end
                PORT_CTRL: begin
                  if (!in_item.data[7]) begin
                    do_pc = 1'b1;
                    if (in_item.data[0]) begin
                      cv = latch_c_r | (8'd1 << in_item.data[3:1]);
                    end else begin
                      cv = latch_c_r & ~(8'd1 << in_item.data[3:1]);
                    end
                  end
                end
                default: begin
                end
              endcase

              // setup strobe on port C
              if (do_pc) begin
                ch = cv[3:1];
                if (setup_prev_r[ch] && !cv[0]) begin
                  if (!gate_r && sounding_r[ch]) begin
                    job_valid = 1'b1;
                    job = '{kind: JOB_NOTE, b0: MIDI_NOTE_OFF + 8'(ch), b1: skey_r[ch]};
                    skey_nxt[ch]     = '0;
                    sounding_nxt[ch] = 1'b0;
                  end else if (gate_r && !sounding_r[ch]) begin
                    if (pitch_cv_r == '0) begin
                      srch_ch_nxt  = ch;
                      srch_cnt_nxt = (ch < 3'd6) ? tcount_r[ch] : 16'h0000;
                      lo_nxt       = '0;
                      hi_nxt       = 7'(PITCH_ENTRIES);
                      state_nxt    = F_SEARCH;
                    end else begin
                      pending_nxt[ch] = 1'b1;
                    end
                  end
                end
                setup_prev_nxt[ch] = cv[0];
                reset_sent_nxt     = 1'b0;
                latch_c_nxt        = {latch_c_r[7:4], cv[3:0]};
              end
            end
            CMD_READ: begin
              job_valid = 1'b1;
              job.kind  = JOB_READ;
              case (in_item.address)
                PORT_A:  job.b0 = latch_a_r;
                PORT_B:  job.b0 = latch_b_r;
                PORT_C:  job.b0 = latch_c_r;
                default: job.b0 = 8'h00;
              endcase
            end
            CMD_TICK: begin
              latch_c_nxt = latch_c_r ^ 8'hF0;
            end
            CMD_RESET: begin
              // send the burst once and clear the note state
              if (!reset_sent_r) begin
                job_valid = 1'b1;
                job = '{kind: JOB_BURST, b0: 8'h00, b1: 8'h00};
                phase_nxt       = '0;
                tcount_nxt      = '{default: 16'h0000};
                pitch_cv_nxt    = '0;
                gate_nxt        = 1'b0;
                skey_nxt        = '{default: 8'h00};
                sounding_nxt    = '0;
                setup_prev_nxt  = '0;
                pending_nxt     = '0;
                rhythm_prev_nxt = 8'hFE;
                reset_sent_nxt  = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      F_SEARCH: begin
        // binary search for the first entry not above the count
        if (lo_r == hi_r) begin
          state_nxt = F_PICK;
        end else if (srch_cnt_r >= pitch_tab(mid)) begin
          hi_nxt = mid;
        end else begin
          lo_nxt = mid + 7'd1;
        end
      end
      F_PICK: begin
        job_valid = 1'b1;
        job = '{kind: JOB_NOTE, b0: MIDI_NOTE_ON + 8'(srch_ch_r), b1: key};
        if (job_ready) begin
          pitch_cv_nxt            = pc_cl;
          sounding_nxt[srch_ch_r] = 1'b1;
          skey_nxt[srch_ch_r]     = key;
          state_nxt               = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  // Hold state, advance on accepted items and search steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= F_IDLE;
      latch_a_r     <= '0;
      latch_b_r     <= '0;
      latch_c_r     <= '0;
      phase_r       <= '0;
      tcount_r      <= '{default: 16'h0000};
      skey_r        <= '{default: 8'h00};
      sounding_r    <= '0;
      setup_prev_r  <= '0;
      pending_r     <= '0;
      rhythm_prev_r <= 8'hFE;
      reset_sent_r  <= 1'b0;
      pitch_cv_r    <= '0;
      gate_r        <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      latch_a_r     <= latch_a_nxt;
      latch_b_r     <= latch_b_nxt;
      latch_c_r     <= latch_c_nxt;
      phase_r       <= phase_nxt;
      tcount_r      <= tcount_nxt;
      skey_r        <= skey_nxt;
      sounding_r    <= sounding_nxt;
      setup_prev_r  <= setup_prev_nxt;
      pending_r     <= pending_nxt;
      rhythm_prev_r <= rhythm_prev_nxt;
      reset_sent_r  <= reset_sent_nxt;
      pitch_cv_r    <= pitch_cv_nxt;
      gate_r        <= gate_nxt;
    end
  end

  // Search operands carry no reset
  always_ff @(posedge clk) begin
    srch_ch_r  <= srch_ch_nxt;
    srch_cnt_r <= srch_cnt_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
  end

endmodule
`default_nettype wire

[hw/rtl/smpb_queue.sv]
// Small job queue between the front end and the byte generator.
`timescale 1ns / 1ps
`default_nettype none
module smpb_queue
  import smpb_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  smpb_job_t push_job,
  output logic      pop_valid,
  input  logic      pop_ready,
  output smpb_job_t pop_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  smpb_job_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt;
  logic [PW-1:0]   rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            push, pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = mem_r[rd_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the job
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/smpb_back.sv]
// Back end: expands held jobs to bytes, one per cycle while out_ready.
`timescale 1ns / 1ps
`default_nettype none
module smpb_back
  import smpb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_ready,
  input  smpb_job_t job,
  output logic      out_valid,
  input  logic      out_ready,
  output smpb_out_t out_item
);

  logic       have_r, have_nxt;
  smpb_job_t  job_r, job_nxt;
  logic [5:0] idx_r, idx_nxt;
  logic [6:0] mask_r, mask_nxt;
  logic       ov_r, ov_nxt;
  smpb_out_t  out_r, out_nxt;

  logic       can_emit;
  logic       done;
  logic [2:0] k;
  logic [6:0] rest;

  assign job_ready = !have_r;
  assign can_emit  = !ov_r || out_ready;
  assign out_valid = ov_r;
  assign out_item  = out_r;

  // Lowest pending drum
  always_comb begin
    k = '0;
    for (int i = 6; i >= 0; i--) begin
      if (mask_r[i]) begin
        k = 3'(i);
      end
    end
    rest = mask_r & ~(7'd1 << k);
  end

  always_comb begin
    have_nxt = have_r;
    job_nxt  = job_r;
    idx_nxt  = idx_r;
    mask_nxt = mask_r;
    ov_nxt   = ov_r && !out_ready;
    out_nxt  = out_r;
    done     = 1'b0;

    if (!have_r) begin
      // take the next job
      if (job_valid) begin
        have_nxt = 1'b1;
        job_nxt  = job;
        idx_nxt  = '0;
        mask_nxt = job.b0[6:0];
      end
    end else if (can_emit) begin
      ov_nxt = 1'b1;
      out_nxt.kind = 1'b0;
      case (job_r.kind)
        JOB_READ: begin
          out_nxt.kind  = 1'b1;
          out_nxt.value = job_r.b0;
          done          = 1'b1;
        end
        JOB_NOTE: begin
          case (idx_r[1:0])
            2'd0:    out_nxt.value = job_r.b0;
            2'd1:    out_nxt.value = job_r.b1;
            default: out_nxt.value = MIDI_VEL;
          endcase
          done = (idx_r == 6'd2);
        end
        JOB_DRUM: begin
          case (idx_r[1:0])
            2'd0:    out_nxt.value = MIDI_DRUM_ON;
            2'd1:    out_nxt.value = drum_key(k);
            default: out_nxt.value = MIDI_VEL;
          endcase
          if (idx_r == 6'd2) begin
            mask_nxt = rest;
            done     = (rest == '0);
          end
        end
        JOB_BURST: begin
          out_nxt.value = burst_byte(idx_r);
          done          = (idx_r == 6'(BURST_LEN - 1));
        end
        default: begin
          out_nxt.value = 8'h00;
          done          = 1'b1;
        end
      endcase
      out_nxt.last = done;
      if (done) begin
        have_nxt = 1'b0;
      end else if (job_r.kind == JOB_DRUM && idx_r == 6'd2) begin
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      have_r <= have_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // Hold job and output payload
  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    idx_r  <= idx_nxt;
    mask_r <= mask_nxt;
    out_r  <= out_nxt;
  end

endmodule
`default_nettype wire

[hw/rtl/sequencer_port_to_midi_bridge.sv]
// Sequencer port to MIDI bridge: accepts one port access per cycle while the front end
// is idle and the job queue has room, and streams MIDI bytes, one result item per cycle
// while a job is held and the result side is ready. Port writes, reads, ticks and note
// offs do not hold the input; a note on holds it while a binary search over the 113-entry
// pitch table runs (up to seven compare steps, one step to settle, one pick step that
// pushes the job once the queue has room). The back end loads each job and then emits
// its bytes: three bytes per note, three per drum, one per read and 51 for the reset
// burst. The job queue holds QDEPTH jobs between the two ends.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sequencer_port_to_midi_bridge
  import smpb_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input logic           clk,
  input logic           rst_n,
  smpb_stream_if.sink   in_ch,
  smpb_stream_if.source out_ch
);

  logic      f_valid, f_ready;
  smpb_job_t f_job;
  logic      b_valid, b_ready;
  smpb_job_t b_job;
  smpb_in_t  in_item;
  smpb_out_t out_item;
  logic      out_valid;

  assign in_item = in_ch.payload;

  smpb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  smpb_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_job    (b_job)
  );

  smpb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job       (b_job),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

  // Read data is always the only result of its item
  `SMPB_ASSERT_IMP(a_read_is_last, out_valid && out_item.kind, out_item.last)
  // The input is taken only while the job queue has room
  `SMPB_ASSERT_IMP(a_ready_needs_room, in_ch.ready, f_ready)
  // Nothing is offered in the cycle after reset
  `SMPB_ASSERT_NXT(a_reset_quiet, !rst_n, !out_valid)

endmodule
`default_nettype wire

[tb/sequencer_port_to_midi_bridge_checker.sv]
// Checker of the port to MIDI bridge: predicts the MIDI bytes of each accepted item and compares.
`timescale 1ns / 1ps
module sequencer_port_to_midi_bridge_checker
  import smpb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  smpb_in_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  smpb_out_t out_item,
  output int        errors,
  output int        pending
);

  // Shadow copy of the bridge state
  logic [7:0]  latch_q [3];
  logic        phase_q [6];
  logic [15:0] count_q [8];
  int          cv_q;
  logic        gate_q;
  logic [7:0]  key_q [8];
  logic        sounding_q [8];
  logic        strobe_q [8];
  logic        waiting_q [8];
  logic [7:0]  rhythm_q;
  logic        burst_done_q;

  smpb_out_t midi_q [$];
  smpb_out_t step_q [$];

  assign pending = midi_q.size();

  task automatic emit(input logic kind, input logic [7:0] value);
    step_q.push_back('{kind: kind, value: value, last: 1'b0});
  endtask

  task automatic clear_voices();
    for (int i = 0; i < 8; i++) begin
      if (i < 6) phase_q[i] = 1'b0;
      count_q[i] = '0;
      key_q[i] = '0;
      sounding_q[i] = 1'b0;
      strobe_q[i] = 1'b0;
      waiting_q[i] = 1'b0;
    end
    cv_q = 0;
    gate_q = 1'b0;
    rhythm_q = 8'hFE;
  endtask

  // Map the channel count to the nearest pitch and sound the note
  task automatic sound_note(input int ch);
    int          idx;
    logic [15:0] cnt;
    logic [15:0] up;
    logic [15:0] dn;
    logic [7:0]  key;
    cnt = count_q[ch];
    idx = PITCH_ENTRIES;
    for (int i = PITCH_ENTRIES - 1; i >= 0; i--) begin
      if (cnt >= PITCH_TAB[i]) idx = i;
    end
    if (idx < PITCH_ENTRIES) begin
      if (idx == 0) begin
        cv_q = 0;
      end else begin
        up = PITCH_TAB[idx-1] - cnt;
        dn = cnt - PITCH_TAB[idx];
        cv_q = (up < dn) ? idx - 1 : idx;
      end
    end
    while (cv_q > 103) cv_q -= 12;
    key = 8'(cv_q + 24);
    emit(1'b0, MIDI_NOTE_ON + 8'(ch));
    emit(1'b0, key);
    emit(1'b0, MIDI_VEL);
    sounding_q[ch] = 1'b1;
    key_q[ch] = key;
  endtask

  task automatic load_count(input int p, input logic [7:0] d);
    if (!phase_q[p]) count_q[p][7:0] = d;
    else count_q[p][15:8] = d;
    phase_q[p] = ~phase_q[p];
    burst_done_q = 1'b0;
    if (!phase_q[p] && waiting_q[p]) begin
      sound_note(p);
      waiting_q[p] = 1'b0;
    end
  endtask

  // Setup strobe falling edge: note off, note on, or hold it pending
  task automatic write_setup(input logic [7:0] d);
    int ch;
    ch = d[3:1];
    if (strobe_q[ch] && !d[0]) begin
      if (!gate_q && sounding_q[ch]) begin
        emit(1'b0, MIDI_NOTE_OFF + 8'(ch));
        emit(1'b0, key_q[ch]);
        emit(1'b0, MIDI_VEL);
        key_q[ch] = '0;
        sounding_q[ch] = 1'b0;
      end else if (gate_q && !sounding_q[ch]) begin
        if (cv_q == 0) sound_note(ch);
        else waiting_q[ch] = 1'b1;
      end
    end
    strobe_q[ch] = d[0];
    burst_done_q = 1'b0;
    latch_q[2][3:0] = d[3:0];
  endtask

  task automatic predict(input smpb_in_t it);
    logic [7:0] v;
    step_q.delete();
    case (it.cmd)
      CMD_WRITE: begin
        if (it.address inside {8'h90, 8'h91, 8'h92}) begin
          load_count(it.address - 8'h90, it.data);
        end else if (it.address inside {8'h94, 8'h95, 8'h96}) begin
          load_count(it.address - 8'h91, it.data);
        end else if (it.address == PORT_A) begin
          gate_q = !it.data[7];
          if (gate_q) cv_q = it.data[5:0];
          burst_done_q = 1'b0;
          latch_q[0] = it.data;
        end else if (it.address == PORT_B) begin
          for (int i = 0; i < 7; i++) begin
            if (rhythm_q[i+1] && !it.data[i+1]) begin
              emit(1'b0, MIDI_DRUM_ON);
              emit(1'b0, DRUM_KEYS[i]);
              emit(1'b0, MIDI_VEL);
            end
          end
          rhythm_q = it.data;
          burst_done_q = 1'b0;
          latch_q[1] = it.data;
        end else if (it.address == PORT_C) begin
          write_setup(it.data);
        end else if (it.address == PORT_CTRL && !it.data[7]) begin
          v = latch_q[2];
          v[it.data[3:1]] = it.data[0];
          write_setup(v);
        end
      end
      CMD_READ: begin
        v = '0;
        if (it.address >= PORT_A && it.address <= PORT_C) v = latch_q[it.address - PORT_A];
        emit(1'b1, v);
      end
      CMD_TICK: latch_q[2] ^= 8'hF0;
      default: begin
        if (!burst_done_q) begin
          emit(1'b0, 8'hF0); emit(1'b0, 8'h7E); emit(1'b0, 8'h7F);
          emit(1'b0, 8'h09); emit(1'b0, 8'h01); emit(1'b0, 8'hF7);
          for (int i = 0; i < 11; i++) begin
            emit(1'b0, 8'hB0 + 8'(i));
            emit(1'b0, 8'h78);
            emit(1'b0, 8'h00);
          end
          for (int i = 0; i < 6; i++) begin
            emit(1'b0, 8'hC0 + 8'(i));
            emit(1'b0, 8'h07);
          end
          clear_voices();
          burst_done_q = 1'b1;
        end
      end
    endcase
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) midi_q.push_back(step_q[i]);
  endtask

  initial begin
    errors = 0;
    for (int i = 0; i < 3; i++) latch_q[i] = '0;
    burst_done_q = 1'b0;
    clear_voices();
  end

  // Predict on input accept, compare on output accept
  always @(posedge clk) begin
    smpb_out_t exp_item;
    if (rst_n) begin
      if (in_valid && in_ready) predict(in_item);
      if (out_valid && out_ready) begin
        if (midi_q.size() == 0) begin
          $display("%0t: unexpected item kind=%0d value=%02h last=%0d", $time,
                   out_item.kind, out_item.value, out_item.last);
          errors++;
        end else begin
          exp_item = midi_q.pop_front();
          if (out_item.kind !== exp_item.kind || out_item.value !== exp_item.value ||
              out_item.last !== exp_item.last) begin
            $display("%0t: mismatch expected kind=%0d value=%02h last=%0d, actual kind=%0d value=%02h last=%0d",
                     $time, exp_item.kind, exp_item.value, exp_item.last,
                     out_item.kind, out_item.value, out_item.last);
            errors++;
          end
        end
      end
    end
  end

endmodule

[tb/sequencer_port_to_midi_bridge_tb.sv]
// Top of the port to MIDI bridge testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module sequencer_port_to_midi_bridge_tb;
  import smpb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic calm = 1'b0;
  int   errors;
  int   pending;
  int   sent = 0;
  int   stall_left = 0;

  smpb_stream_if #(.T(smpb_in_t))  in_ch ();
  smpb_stream_if #(.T(smpb_out_t)) out_ch ();

  sequencer_port_to_midi_bridge u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sequencer_port_to_midi_bridge_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_ch.payload),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.payload),
    .errors    (errors),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  // Stall the result side in random bursts
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    if (calm) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 9) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Send one item, with an optional gap in front, and hold until accepted
  task automatic send(input logic [1:0] cmd, input logic [7:0] addr, input logic [7:0] data);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= '{cmd: cmd, address: addr, data: data};
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  function automatic logic [7:0] count_port(input logic [2:0] ch);
    return (ch < 3) ? 8'h90 + 8'(ch) : 8'h91 + 8'(ch);
  endfunction

  // Gate open, strobe the channel, then load its counter if it has one
  task automatic play_note(input logic [2:0] ch);
    logic [5:0] cv;
    cv = ($urandom_range(0, 2) == 0) ? 6'd0 : 6'($urandom);
    send(CMD_WRITE, PORT_A, {1'b0, 1'($urandom), cv});
    send(CMD_WRITE, PORT_C, {4'($urandom), ch, 1'b1});
    send(CMD_WRITE, PORT_C, {4'($urandom), ch, 1'b0});
    if (ch < 6) begin
      send(CMD_WRITE, count_port(ch), 8'($urandom));
      send(CMD_WRITE, count_port(ch), ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15))
                                                                   : 8'($urandom));
    end
  endtask

  // Gate closed, strobe the channel
  task automatic stop_note(input logic [2:0] ch);
    send(CMD_WRITE, PORT_A, {1'b1, 7'($urandom)});
    send(CMD_WRITE, PORT_C, {4'($urandom), ch, 1'b1});
    send(CMD_WRITE, PORT_C, {4'($urandom), ch, 1'b0});
  endtask

  initial begin
    int r;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: burst, repeated reset, reads, drums, note edge cases
    send(CMD_RESET, 8'h00, 8'h00);
    send(CMD_RESET, 8'hFF, 8'hFF);
    send(CMD_READ, PORT_A, 8'h00);
    send(CMD_READ, 8'h00, 8'h00);
    send(CMD_READ, 8'hFF, 8'h00);
    send(CMD_WRITE, PORT_B, 8'h00);
    send(CMD_WRITE, PORT_B, 8'hFF);
    send(CMD_READ, PORT_B, 8'h00);
    send(CMD_TICK, 8'h00, 8'h00);
    send(CMD_READ, PORT_C, 8'h00);
    send(CMD_WRITE, PORT_A, 8'h00);
    send(CMD_WRITE, PORT_C, 8'h01);
    send(CMD_WRITE, PORT_C, 8'h00);
    send(CMD_WRITE, PORT_A, 8'h3F);
    send(CMD_WRITE, PORT_C, 8'h03);
    send(CMD_WRITE, PORT_C, 8'h02);
    send(CMD_WRITE, 8'h91, 8'hFF);
    send(CMD_WRITE, 8'h91, 8'hFF);
    send(CMD_WRITE, 8'h93, 8'h55);
    send(CMD_WRITE, PORT_CTRL, 8'h85);
    send(CMD_WRITE, PORT_A, 8'h80);
    send(CMD_WRITE, PORT_CTRL, 8'h01);
    send(CMD_WRITE, PORT_CTRL, 8'h00);
    stop_note(3'd1);

    // Random: mostly note sequences, some noise
    while (sent < 310) begin
      if (sent >= 270) calm = 1'b1;
      r = $urandom_range(0, 9);
      case (r)
        0, 1, 2, 3: play_note(3'($urandom_range(0, 7)));
        4:          stop_note(3'($urandom_range(0, 7)));
        5:          send(CMD_WRITE, PORT_B, 8'($urandom));
        6:          send(CMD_READ, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                   : 8'($urandom_range(8'h98, 8'h9A)), 8'($urandom));
        7:          send(CMD_TICK, 8'($urandom), 8'($urandom));
        8:          send(CMD_WRITE, ($urandom_range(0, 1) == 0) ? 8'($urandom)
                                    : 8'($urandom_range(8'h90, 8'h9C)), 8'($urandom));
        default: begin
          if ($urandom_range(0, 2) == 0) send(CMD_RESET, 8'($urandom), 8'($urandom));
          else send(CMD_WRITE, PORT_CTRL, 8'($urandom));
        end
      endcase
    end
    calm = 1'b1;
    in_ch.valid <= 1'b0;

    // Let the checker see the last accepted item before draining
    @(posedge clk);
    // Drain, then keep watching for stray items
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
